// ===== src/sitbs_pkg.sv =====
// Shared types and constants for the sorted identifier table with binary search.
package sitbs_pkg;

    localparam int unsigned DEF_MAX_ENTRIES = 64;
    localparam int unsigned CHANNEL_ID_W    = 16;
    localparam int unsigned ENTRY_INDEX_W   = 6;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        RES_APPEND,
        RES_FULL,
        RES_HIT,
        RES_MISS
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     step;
        logic     write;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic hit;
        logic more;
    } t_dp_stat;

endpackage

// ===== src/sitbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sitbs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sitbs_dp.sv =====
// Datapath: key, entry count, search bounds, table memory and result registers.
module sitbs_dp #(
    parameter int unsigned MAX_ENTRIES = sitbs_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [sitbs_pkg::CHANNEL_ID_W-1:0]     i_channel_id,
    input  sitbs_pkg::t_dp_cmd                     i_cmd,
    output sitbs_pkg::t_dp_stat                    o_stat,
    output logic                                   o_found,
    output logic [sitbs_pkg::ENTRY_INDEX_W-1:0]    o_entry_index,
    output logic                                   o_table_full
);
    import sitbs_pkg::*;

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = (AW > ENTRY_INDEX_W) ? AW : ENTRY_INDEX_W;

    logic [CHANNEL_ID_W-1:0]  r_key;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_low;
    logic [CW-1:0]            r_hi;
    logic [AW-1:0]            r_mid;
    logic                     r_found;
    logic [ENTRY_INDEX_W-1:0] r_index;
    logic                     r_full;

    logic [CHANNEL_ID_W-1:0]  rdata;
    logic                     key_gt;
    logic                     key_eq;
    logic [CW-1:0]            n_low;
    logic [CW-1:0]            n_hi;
    logic [CW:0]              sum_next;
    logic [CW:0]              sum_init;
    logic [AW-1:0]            n_mid;
    logic [AW-1:0]            init_mid;
    logic [AW-1:0]            raddr;
    logic [XW-1:0]            idx_app;
    logic [XW-1:0]            idx_hit;

    sitbs_ram #(
        .WIDTH (CHANNEL_ID_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (AW'(r_count)),
        .i_wdata (r_key),
        .i_re    (i_cmd.load | i_cmd.step),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Upper bound is kept exclusive, so the probe is floor((low + hi - 1) / 2).
    always_comb begin
        key_eq   = (r_key == rdata);
        key_gt   = (r_key > rdata);
        n_low    = key_gt ? (CW'(r_mid) + CW'(1)) : r_low;
        n_hi     = key_gt ? r_hi : CW'(r_mid);
        sum_next = {1'b0, n_low} + {1'b0, n_hi} - (CW+1)'(1);
        n_mid    = AW'(sum_next >> 1);
        sum_init = {1'b0, r_count} - (CW+1)'(1);
        init_mid = AW'(sum_init >> 1);
        raddr    = i_cmd.load ? init_mid : n_mid;
        idx_app  = XW'(r_count);
        idx_hit  = XW'(r_mid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_channel_id;
            r_low <= '0;
            r_hi  <= r_count;
            r_mid <= init_mid;
        end else if (i_cmd.step) begin
            r_low <= n_low;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_APPEND: begin
                    r_found <= 1'b1;
                    r_index <= idx_app[ENTRY_INDEX_W-1:0];
                    r_full  <= 1'b0;
                end
                RES_FULL: begin
                    r_found <= 1'b0;
                    r_index <= '0;
                    r_full  <= 1'b1;
                end
                RES_HIT: begin
                    r_found <= 1'b1;
                    r_index <= idx_hit[ENTRY_INDEX_W-1:0];
                    r_full  <= 1'b0;
                end
                RES_MISS: begin
                    r_found <= 1'b0;
                    r_index <= '0;
                    r_full  <= 1'b0;
                end
                default: begin
                    r_found <= 1'b0;
                    r_index <= '0;
                    r_full  <= 1'b0;
                end
            endcase
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(MAX_ENTRIES));
    assign o_stat.hit        = key_eq;
    assign o_stat.more       = (n_low < n_hi);

    assign o_found       = r_found;
    assign o_entry_index = r_index;
    assign o_table_full  = r_full;

endmodule

// ===== src/sitbs_ctrl.sv =====
// Controller: sequences append and lookup items and owns the result valid flag.
module sitbs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  sitbs_pkg::t_dp_stat  i_stat,
    output sitbs_pkg::t_dp_cmd   o_dp_cmd
);
    import sitbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_op;
    logic    n_op;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.write    = 1'b0;
        cmd.res_load = 1'b0;
        cmd.res_sel  = RES_MISS;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_op     = i_cmd;
                    if (i_cmd == CMD_APPEND || i_stat.count_zero) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                    if (r_op == CMD_LOOKUP) begin
                        cmd.res_sel = RES_MISS;
                    end else if (i_stat.full) begin
                        cmd.res_sel = RES_FULL;
                    end else begin
                        cmd.write   = 1'b1;
                        cmd.res_sel = RES_APPEND;
                    end
                end
            end
            S_SEARCH: begin
                priority if (i_stat.hit) begin
                    if (out_free) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_HIT;
                        n_state      = S_IDLE;
                    end
                end else if (!i_stat.more) begin
                    if (out_free) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_MISS;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= CMD_APPEND;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dp_cmd    = cmd;

endmodule

// ===== src/sorted_id_table_binary_search_unit.sv =====
// Top level of the sorted identifier table with binary-search lookup.
//
// The block holds up to MAX_ENTRIES 16-bit channel identifiers and answers
// lookups with a binary search whose probe is floor((low+high)/2). The user
// must append them in ascending order; the block does not enforce it. Every
// input transfer gives exactly one result transfer. An append (cmd 0) stores
// the identifier at the next free slot and returns found=1 with its index, or
// table_full=1 when the table is full. A lookup (cmd 1) returns found=1 and
// the index of the first matching entry the probe sequence meets, else found=0,
// index 0. Items are handled one at a time. An append is the input transfer
// followed by the write once the output register is free. A lookup starts
// the first table read with the input transfer and then advances one probe
// per cycle, since each probe compares the registered read of the single
// table read port and issues the next address in the same cycle; with N
// entries that is at most ceil(log2(N+1)) probes. A finished result sits in
// an output register; the block stalls only if a second result is ready
// while the first has not yet been taken. The table memory needs no clearing
// after reset: only data read from written entries is used.
module sorted_id_table_binary_search_unit #(
    parameter int unsigned MAX_ENTRIES = sitbs_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [sitbs_pkg::CHANNEL_ID_W-1:0]  i_channel_id,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [sitbs_pkg::ENTRY_INDEX_W-1:0] o_entry_index,
    output logic                                o_table_full
);
    import sitbs_pkg::*;

    // Command and status between sequencer and datapath.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sitbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    // Hold the key and bounds, advance the search one probe per cycle.
    sitbs_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_channel_id  (i_channel_id),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_found       (o_found),
        .o_entry_index (o_entry_index),
        .o_table_full  (o_table_full)
    );

endmodule

// ===== src/sitbs_checker.sv =====
// Port-level checker for the identifier table, bound to the top level.
module sitbs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_found,
    input logic [sitbs_pkg::ENTRY_INDEX_W-1:0] o_entry_index,
    input logic                                o_table_full
);

    // One item at a time: no second transfer in the cycle after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again straight after a transfer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found) && $stable(o_entry_index)
             && $stable(o_table_full)))
        else $error("stalled result changed");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (!o_found && o_entry_index == '0))
        else $error("refused append reports a stored entry");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_entry_index == '0))
        else $error("miss carries a non-zero index");

endmodule

bind sorted_id_table_binary_search_unit sitbs_checker u_sitbs_checker (.*);

// ===== test/sorted_id_table_binary_search_unit_tb.sv =====
// Self-checking testbench for the sorted identifier table with binary-search lookup.
module sorted_id_table_binary_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sitbs_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int ID_W        = CHANNEL_ID_W;
    localparam int IDX_W       = ENTRY_INDEX_W;
    localparam int N_RANDOM    = 1250;
    // Worst case is roughly 1265 transfers, each with a full search,
    // a long sender gap and a long receiver stall; allow several times that.
    localparam int CYCLE_LIMIT = 800_000;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic             full;
    } t_reply;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] id;
        bit              typed;
        t_reply          want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_cmd;
    logic [ID_W-1:0]  i_channel_id;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_found;
    logic [IDX_W-1:0] o_entry_index;
    logic             o_table_full;

    // Shadow copy of the table, updated as each input transfer is accepted.
    logic [ID_W-1:0] shadow_ids [TABLE_DEPTH];
    int              shadow_count;
    // Replies owed by the block, oldest first.
    t_reply          awaited_replies [$];
    t_dir_row        dir_rows [$];
    int              error_count;
    int              cycle_count;

    sorted_id_table_binary_search_unit #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_channel_id  (i_channel_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_entry_index (o_entry_index),
        .o_table_full  (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one command to the shadow table and return the reply it must give.
    // Lookups walk the same probe sequence as the block, sorted table or not.
    function automatic t_reply apply_table_op(input logic cmd, input logic [ID_W-1:0] key);
        t_reply r;
        int     lo;
        int     hi;
        int     mid;
        r = '0;
        if (cmd == CMD_APPEND) begin
            if (shadow_count >= TABLE_DEPTH) begin
                r.full = 1'b1;
            end else begin
                shadow_ids[shadow_count] = key;
                r.found = 1'b1;
                r.idx   = shadow_count[IDX_W-1:0];
                shadow_count++;
            end
        end else begin
            lo = 0;
            hi = shadow_count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (shadow_ids[mid] == key) begin
                    r.found = 1'b1;
                    r.idx   = mid[IDX_W-1:0];
                    break;
                end else if (key > shadow_ids[mid]) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic cmd, input logic [ID_W-1:0] id,
                                         input bit typed, input logic found,
                                         input int idx, input logic full);
        t_dir_row row;
        row.cmd        = cmd;
        row.id         = id;
        row.typed      = typed;
        row.want.found = found;
        row.want.idx   = idx[IDX_W-1:0];
        row.want.full  = full;
        return row;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Drive one item at the falling edge and hold it until the transfer.
    // The reply is booked at the very edge that accepts the item.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input bit typed, input t_reply typed_want);
        t_reply predicted;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_channel_id <= id;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_table_op(cmd, id);
        awaited_replies.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid for the given number of cycles; zero keeps the stream going.
    task automatic hold_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Receiver: runs of ready, broken by stalls, with the odd long clean stretch.
    initial begin : receiver
        int run;
        int gap;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0)
                run = $urandom_range(80, 150);
            else
                run = $urandom_range(1, 12);
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Compare every result transfer with the oldest owed reply.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("result with no reply owed", o_found, 0);
            end else begin
                want = awaited_replies.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_entry_index !== want.idx)
                    report_mismatch("entry_index", o_entry_index, want.idx);
                if (o_table_full !== want.full)
                    report_mismatch("table_full", o_table_full, want.full);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_id_table_binary_search_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row        row;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] last_id;
        logic            cmd;
        int              remaining;
        int              burst_left;
        int              r;
        int              next_id;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_APPEND;
        i_channel_id = '0;
        i_out_ready  = 1'b0;
        shadow_count = 0;
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;

        // Directed rows: empty-table lookups, extremes of the identifier,
        // a duplicate entry and an entry out of ascending order.
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h0000, 1, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'hFFFF, 1, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_APPEND, 16'h0000, 1, 1, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h0000, 1, 1, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'hFFFF, 1, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_APPEND, 16'h0001, 1, 1, 1, 0));
        dir_rows.push_back(dir_row(CMD_APPEND, 16'h0001, 1, 1, 2, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h0001, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_APPEND, 16'h8000, 1, 1, 3, 0));
        dir_rows.push_back(dir_row(CMD_APPEND, 16'h7FFF, 1, 1, 4, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h7FFF, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h8000, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h5555, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'hAAAA, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_LOOKUP, 16'h0002, 0, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            send_item(row.cmd, row.id, row.typed, row.want);
            hold_sender(pick_gap());
        end

        // Random part: the table fills slowly with mostly ascending identifiers,
        // lookups mostly aim at stored entries or their neighbours, and the last
        // appends run into a full table.
        last_id = 16'h8000;
        for (int k = 0; k < N_RANDOM; k++) begin
            remaining = N_RANDOM - k;
            if (remaining <= TABLE_DEPTH - shadow_count + 4 || $urandom_range(0, 9) == 0)
                cmd = CMD_APPEND;
            else
                cmd = CMD_LOOKUP;

            r = $urandom_range(0, 99);
            if (cmd == CMD_APPEND) begin
                if (shadow_count < TABLE_DEPTH && r < 88) begin
                    next_id = int'(last_id) + $urandom_range(0, 1100);
                    if (next_id > 16'hFFFF)
                        next_id = 16'hFFFF;
                    last_id = next_id[ID_W-1:0];
                    key     = last_id;
                end else begin
                    key = ID_W'($urandom_range(0, 16'hFFFF));
                end
            end else if (shadow_count == 0 || r < 20) begin
                key = ID_W'($urandom_range(0, 16'hFFFF));
            end else begin
                key = shadow_ids[$urandom_range(0, shadow_count - 1)];
                if (r >= 85)
                    key = key + 16'd1;
                else if (r >= 70)
                    key = key - 16'd1;
            end

            send_item(cmd, key, 0, '0);

            // Halfway through, hold off until every owed reply is in.
            if (k == N_RANDOM / 2) begin
                hold_sender(1);
                while (awaited_replies.size() != 0) @(posedge i_clk);
            end else if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 39) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else begin
                hold_sender(pick_gap());
            end
        end

        hold_sender(1);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        // Let any stray result show itself before the verdict.
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("sorted_id_table_binary_search_unit_tb: done, clean");
        else
            $display("sorted_id_table_binary_search_unit_tb: done, errors");
        $finish;
    end

endmodule
